[design/frg_pkg.sv]
`timescale 1ns / 1ps

package frg_pkg;

  // Width of every numeric field on the ports; WORD_BITS selects the low part that is used.
  localparam int unsigned FRG_FIELD_BITS = 64;

  typedef struct packed {
    logic                      kind;
    logic [FRG_FIELD_BITS-1:0] numerator_bits;
    logic [FRG_FIELD_BITS-1:0] denominator;
  } frg_in_t;

  typedef struct packed {
    logic [FRG_FIELD_BITS-1:0] numerator_magnitude;
    logic                      numerator_negative;
    logic [FRG_FIELD_BITS-1:0] reduced_denominator;
  } frg_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_GCD,
    S_DIV,
    S_HOLD
  } frg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic classify;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic store;
  } frg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } frg_status_t;

endpackage

[design/frg_ctrl.sv]
`timescale 1ns / 1ps

module frg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  frg_pkg::frg_status_t st,
  output frg_pkg::frg_cmd_t    cmd
);
  import frg_pkg::*;

  frg_state_t state;
  frg_state_t state_next;
  logic       res_valid;
  logic       res_valid_next;
  logic       out_free;

  assign out_free     = !res_valid || result_ready;
  assign item_ready   = (state == S_IDLE);
  assign result_valid = res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_valid) state_next = S_SETUP;
      S_SETUP: state_next = st.special ? S_HOLD : S_GCD;
      S_GCD:   if (st.gcd_done) state_next = S_DIV;
      S_DIV:   if (st.div_done) state_next = S_HOLD;
      S_HOLD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load     = item_valid;
      S_SETUP: cmd.classify = 1'b1;
      S_GCD: begin
        cmd.gcd_step = !st.gcd_done;
        cmd.div_init = st.gcd_done;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_HOLD:  cmd.store    = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    res_valid_next = res_valid && !result_ready;
    if (cmd.store) res_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == S_SETUP)
    else $error("accepted beat did not start setup");

  a_valid_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_HOLD))
    else $error("result raised outside the hold state");
`endif

endmodule

[design/frg_datapath.sv]
`timescale 1ns / 1ps

module frg_datapath #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  frg_pkg::frg_in_t     item,
  input  frg_pkg::frg_cmd_t    cmd,
  output frg_pkg::frg_status_t st,
  output frg_pkg::frg_out_t    result
);
  import frg_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned KW = $clog2(W);

  logic [W-1:0]  a, b, a_next, b_next;
  logic [KW-1:0] k, k_next;
  logic [W-1:0]  g;
  logic [W-1:0]  qm, qd;
  logic [W:0]    rm, rd;
  logic [KW-1:0] cnt;
  logic          neg, spec;
  frg_out_t      res;

  logic [W-1:0]  nb_in, den_in, mag_in;
  logic          neg_in;
  logic [W:0]    rm_sh, rd_sh, rm_sub, rd_sub;
  logic          rm_ge, rd_ge;
  frg_out_t      res_next;

  // Input word: magnitude and sign of the numerator.
  assign nb_in  = item.numerator_bits[W-1:0];
  assign den_in = item.denominator[W-1:0];
  assign neg_in = item.kind && nb_in[W-1];
  assign mag_in = neg_in ? (~nb_in + W'(1)) : nb_in;

  assign st.special  = (a == '0) || (b == '0) || (b == W'(1));
  assign st.gcd_done = (a == b);
  assign st.div_done = (cnt == '0);

  // One binary gcd step: halve an even operand, or replace the larger odd one
  // by half the difference. Common factors of two are counted in k.
  always_comb begin
    a_next = a;
    b_next = b;
    k_next = k;
    if (!a[0] && !b[0]) begin
      a_next = a >> 1;
      b_next = b >> 1;
      k_next = k + KW'(1);
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (a > b) begin
      a_next = (a - b) >> 1;
    end else if (b > a) begin
      b_next = (b - a) >> 1;
    end
  end

  // Two restoring dividers share the divisor g.
  assign rm_sh  = {rm[W-1:0], qm[W-1]};
  assign rd_sh  = {rd[W-1:0], qd[W-1]};
  assign rm_ge  = rm_sh >= {1'b0, g};
  assign rd_ge  = rd_sh >= {1'b0, g};
  assign rm_sub = rm_sh - {1'b0, g};
  assign rd_sub = rd_sh - {1'b0, g};

  always_comb begin
    if (!spec) begin
      res_next.numerator_magnitude = FRG_FIELD_BITS'(qm);
      res_next.numerator_negative  = neg;
      res_next.reduced_denominator = FRG_FIELD_BITS'(qd);
    end else if (qm == '0) begin
      res_next.numerator_magnitude = '0;
      res_next.numerator_negative  = 1'b0;
      res_next.reduced_denominator = FRG_FIELD_BITS'(1);
    end else if (qd == W'(1)) begin
      res_next.numerator_magnitude = FRG_FIELD_BITS'(qm);
      res_next.numerator_negative  = neg;
      res_next.reduced_denominator = FRG_FIELD_BITS'(1);
    end else begin
      res_next.numerator_magnitude = FRG_FIELD_BITS'(1);
      res_next.numerator_negative  = neg;
      res_next.reduced_denominator = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= mag_in;
      b   <= den_in;
      qm  <= mag_in;
      qd  <= den_in;
      neg <= neg_in;
      k   <= '0;
    end else if (cmd.gcd_step) begin
      a <= a_next;
      b <= b_next;
      k <= k_next;
    end else if (cmd.div_step) begin
      rm  <= rm_ge ? rm_sub : rm_sh;
      rd  <= rd_ge ? rd_sub : rd_sh;
      qm  <= {qm[W-2:0], rm_ge};
      qd  <= {qd[W-2:0], rd_ge};
      cnt <= cnt - KW'(1);
    end
    if (cmd.classify) spec <= st.special;
    if (cmd.div_init) begin
      g   <= a << k;
      rm  <= '0;
      rd  <= '0;
      cnt <= KW'(W - 1);
    end
    if (cmd.store) res <= res_next;
  end

  assign result = res;

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_step |=> (a != '0) && (b != '0))
    else $error("gcd operand reached zero");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> g != '0)
    else $error("zero divisor after gcd");

  a_exact_division: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && st.div_done |=> (rm == '0) && (rd == '0))
    else $error("division by gcd left a remainder");
`endif

endmodule

[design/fraction_reduce_gcd_top.sv]
`timescale 1ns / 1ps

// Fraction reduction to lowest terms.
// Input channel (item_valid / item_ready / item): one beat carries a fraction,
// a numerator word read as unsigned (kind = 0) or two's complement (kind = 1)
// and an unsigned denominator word; only the low WORD_BITS bits of each count.
// Output channel (result_valid / result_ready / result): one beat per input
// beat with the reduced magnitude, its sign and the reduced denominator.
// A zero numerator gives 0 over 1, a denominator of one passes the numerator
// over 1, and a zero denominator gives plus or minus 1 over 0.
// The special cases skip the gcd loop and the divider. For the others, the work
// is set by the binary gcd loop, which removes at least one bit of an operand
// per cycle, followed by a restoring divider pass that divides both words by
// the gcd at once. One fraction is in work at a time. The next beat is taken
// in the cycle after the previous result is parked in the output register,
// even if that result is not yet taken.
// If the receiver stalls, a finished fraction waits in the hold state until
// the output register frees. Synchronous reset returns the controller to idle
// and drops result_valid; no other state survives between fractions.
module fraction_reduce_gcd_top #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  frg_pkg::frg_in_t item,
  output logic             result_valid,
  input  logic             result_ready,
  output frg_pkg::frg_out_t result
);
  import frg_pkg::*;

  // Commands and status between the sequencer and the arithmetic.
  frg_cmd_t    cmd;
  frg_status_t st;

  frg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .st           (st),
    .cmd          (cmd)
  );

  frg_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .result (result)
  );

`ifndef SYNTHESIS
  // A result is never overwritten while it waits for the receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !cmd.store)
    else $error("stored over a pending result");
`endif

endmodule
